### design/irt_pkg.sv
// ----------------------------------------------------------------------------
// irt_pkg
// Shared sizes, status codes and sequencer states of the interval reservation
// table.
// ----------------------------------------------------------------------------
package irt_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int TIME_W   = 32;

  typedef enum logic [1:0] {
    ST_BOOKED  = 2'd0,
    ST_OVERLAP = 2'd1,
    ST_INVALID = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_SCAN,
    SEQ_LAST,
    SEQ_DECIDE,
    SEQ_DONE
  } seq_state_t;

endpackage

### design/interval_reservation_table_top.sv
// ----------------------------------------------------------------------------
// interval_reservation_table_top
// Books half-open spans [start_time, end_time) into a table of spans that
// never overlap, answering each request with one status code.
//
// Request channel: start_time, end_time with req_valid / req_stall. A
// transaction is taken when req_valid is high and req_stall is low.
// Response channel: status with rsp_valid / rsp_stall, held while stalled.
// Status: 0 booked, 1 overlaps a stored span, 2 invalid span, 3 table full.
//
// An invalid span skips the scan and goes straight to the response step. A
// valid span scans each of the N stored spans through one shared pair of
// signed comparators, one entry per cycle from a registered memory read,
// then decides and answers. req_stall is high meanwhile.
// The response register lets a new request start while the previous status
// still waits; a finished request waits in its last step until the response
// register frees up, so a stalled receiver eventually stalls the requester.
// Reset empties the table at once (the fill count is cleared) and drops any
// pending response; no clearing pass is needed.
// ----------------------------------------------------------------------------
module interval_reservation_table_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  logic [irt_pkg::TIME_W-1:0] start_time,
  input  logic [irt_pkg::TIME_W-1:0] end_time,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output logic [1:0]                 status
);
  import irt_pkg::*;

  logic [TIME_W-1:0] span_start [CAPACITY];
  logic [TIME_W-1:0] span_end   [CAPACITY];

  seq_state_t        state, state_next;
  logic [CNT_W-1:0]  span_count;
  logic [IDX_W-1:0]  scan_idx, scan_idx_next;
  logic [TIME_W-1:0] req_start, req_end;
  logic [TIME_W-1:0] rd_start, rd_end;
  logic              cmp_pending;
  logic              hit, hit_next;
  status_t           res, res_next;
  logic              req_take;
  logic              bad_span;
  logic              entry_hit;
  logic              wr_en;
  logic              cnt_inc;
  logic              rsp_load;

  assign req_stall = (state != SEQ_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign bad_span  = ($signed(end_time) <= $signed(start_time));

  // shared overlap compare on the registered entry
  assign entry_hit = ($signed(rd_start) < $signed(req_end)) &&
                     ($signed(req_start) < $signed(rd_end));

  always_comb begin
    state_next    = state;
    scan_idx_next = scan_idx;
    hit_next      = hit;
    res_next      = res;
    wr_en         = 1'b0;
    cnt_inc       = 1'b0;
    rsp_load      = 1'b0;
    unique case (state)
      SEQ_IDLE: begin
        if (req_take) begin
          hit_next      = 1'b0;
          scan_idx_next = '0;
          if (bad_span) begin
            res_next   = ST_INVALID;
            state_next = SEQ_DONE;
          end else if (span_count == '0) begin
            state_next = SEQ_DECIDE;
          end else if (span_count == CNT_W'(1)) begin
            state_next = SEQ_LAST;
          end else begin
            state_next = SEQ_SCAN;
          end
        end
      end
      SEQ_SCAN: begin
        if (cmp_pending && entry_hit) hit_next = 1'b1;
        scan_idx_next = scan_idx + IDX_W'(1);
        if (CNT_W'(scan_idx_next) == span_count - CNT_W'(1)) begin
          state_next = SEQ_LAST;
        end
      end
      SEQ_LAST: begin
        if (entry_hit) hit_next = 1'b1;
        state_next = SEQ_DECIDE;
      end
      SEQ_DECIDE: begin
        priority if (hit) begin
          res_next = ST_OVERLAP;
        end else if (span_count == CNT_W'(CAPACITY)) begin
          res_next = ST_FULL;
        end else begin
          res_next = ST_BOOKED;
          wr_en    = 1'b1;
          cnt_inc  = 1'b1;
        end
        state_next = SEQ_DONE;
      end
      SEQ_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_load   = 1'b1;
          state_next = SEQ_IDLE;
        end
      end
      default: state_next = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= SEQ_IDLE;
      span_count  <= '0;
      cmp_pending <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      cmp_pending <= (state_next == SEQ_SCAN) || (state_next == SEQ_LAST);
      if (cnt_inc) span_count <= span_count + CNT_W'(1);
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_idx <= scan_idx_next;
    hit      <= hit_next;
    res      <= res_next;
    if (req_take) begin
      req_start <= start_time;
      req_end   <= end_time;
    end
    if (rsp_load) status <= res;
  end

  // span memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      span_start[span_count[IDX_W-1:0]] <= req_start;
      span_end[span_count[IDX_W-1:0]]   <= req_end;
    end
    rd_start <= span_start[scan_idx_next];
    rd_end   <= span_end[scan_idx_next];
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    span_count <= CNT_W'(CAPACITY))
    else $error("span count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (state == SEQ_DECIDE && !hit && span_count != CNT_W'(CAPACITY))
      |=> (span_count == $past(span_count) + CNT_W'(1)) && (res == ST_BOOKED))
    else $error("booking did not advance the table");

  a_invalid_path: assert property (@(posedge clk) disable iff (rst)
    (req_take && bad_span) |=> (state == SEQ_DONE) && (res == ST_INVALID))
    else $error("invalid span not reported");

  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == SEQ_DONE)
    else $error("response raised outside the done step");

endmodule
